// ===== design/svd_pkg.sv =====
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types, constants and the quarter-wave sine function used by the
// space-vector PWM duty generator.
// ----------------------------------------------------------------------------
package svd_pkg;

    // Sector boundaries on the 16-bit angle scale (65536 is one full turn).
    localparam logic [15:0] DEG60  = 16'd10923;
    localparam logic [15:0] DEG120 = 16'd21845;
    localparam logic [15:0] DEG180 = 16'd32768;
    localparam logic [15:0] DEG240 = 16'd43691;
    localparam logic [15:0] DEG300 = 16'd54613;

    // Full-scale Q15 amplitude of the sine table.
    localparam logic [14:0] AMP_Q15 = 15'h7fff;

    // Register reset values.
    localparam logic [15:0] DEPTH_LIMIT_RESET = 16'd60293;
    localparam logic [15:0] PWM_PERIOD_RESET  = 16'd4800;
    localparam logic [13:0] MARGIN_RESET      = 14'd48;

    localparam real HALF_PI = 1.5707963267948966;

    // Sixty-degree sectors, numbered 1 to 6.
    typedef enum logic [2:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } svd_sector_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DEPTH_LIMIT = 2'd0,
        REG_PWM_PERIOD  = 2'd1,
        REG_MARGIN      = 2'd2
    } svd_reg_t;

    // Configuration register file.
    typedef struct packed {
        logic [15:0] depth_limit;
        logic [15:0] pwm_period;
        logic [13:0] margin;
    } svd_cfg_t;

    // Signed sines and scaled depth, handed from the sine lookup.
    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic [15:0]        scale;
        svd_sector_t        sec;
    } svd_sine_t;

    // Unpermuted compare times, handed to the output limiter.
    typedef struct packed {
        logic [16:0] ta;
        logic [16:0] tb;
        logic [16:0] tc;
        svd_sector_t sec;
    } svd_time_t;

    // Q15 sine of a quarter-wave position r in 0..16384 (16384 is 90 degrees).
    // The sine is truncated to Q32 first and then rounded to Q15.
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [14:0] quarter_sine_q15(input int unsigned r);
        real    x;
        real    s;
        longint s32;
        longint v;
        x   = HALF_PI * real'(r) / 16384.0;
        s   = $sin(x);
        s32 = longint'($floor(s * 4294967296.0));
        if (s32 < 0) begin
            s32 = 0;
        end
        v = (s32 * 32767 + 64'sh80000000) >>> 32;
        if (v > longint'(AMP_Q15)) begin
            v = longint'(AMP_Q15);
        end
        return v[14:0];
    endfunction

endpackage

// ===== design/svpwm_duty_generator.sv =====
// ----------------------------------------------------------------------------
// svpwm_duty_generator
// Centre-aligned space-vector PWM compare generator for three phases.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_axis channel carries a modulation depth and an
//   electrical angle; each yields exactly one transaction on the m_axis
//   channel with the three phase compare values and the sector number.
//   The cfg channel writes depth_limit (index 0), pwm_period (index 1) and
//   the dead-time margin (index 2); it is always ready. The user must write
//   it only while idle; the block itself does not enforce this.
//   A transaction passes through registered stages on its way to m_axis. The
//   stages are address decode, sine table read with depth scaling,
//   active-vector multiply, zero-vector split, and the limit stage into the
//   output register. Throughput is one transaction per cycle while
//   m_axis_tready is high; every stage holds one item and advances when
//   the stage after it is empty or moving.
//   When the receiver stalls, the pipeline fills and s_axis_tready falls once
//   all five stages hold data; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module svpwm_duty_generator
    import svd_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // depth[15:0], angle[31:16]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // compare_a[14:0], compare_b[29:15],
                                        // compare_c[44:30], sector[47:45]
);

    svd_cfg_t  cfg_reg;
    svd_cfg_t  cfg_next;

    logic      sine_valid;
    logic      sine_ready;
    svd_sine_t sine_data;
    logic      time_valid;
    logic      time_ready;
    svd_time_t time_data;

    logic [14:0] compare_a;
    logic [14:0] compare_b;
    logic [14:0] compare_c;
    logic [2:0]  sector;

    // Register writes; indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEPTH_LIMIT: cfg_next.depth_limit = cfg_data;
                REG_PWM_PERIOD:  cfg_next.pwm_period  = cfg_data;
                REG_MARGIN:      cfg_next.margin      = cfg_data[13:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_limit <= DEPTH_LIMIT_RESET;
            cfg_reg.pwm_period  <= PWM_PERIOD_RESET;
            cfg_reg.margin      <= MARGIN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    svd_sine_lookup #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_depth  (s_axis_tdata[15:0]),
        .in_angle  (s_axis_tdata[31:16]),
        .out_valid (sine_valid),
        .out_ready (sine_ready),
        .out_data  (sine_data)
    );

    svd_vector_time u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sine_valid),
        .in_ready  (sine_ready),
        .in_data   (sine_data),
        .out_valid (time_valid),
        .out_ready (time_ready),
        .out_data  (time_data)
    );

    svd_compare_limit u_limit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (time_valid),
        .in_ready      (time_ready),
        .in_data       (time_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_compare_a (compare_a),
        .out_compare_b (compare_b),
        .out_compare_c (compare_c),
        .out_sector    (sector)
    );

    assign m_axis_tdata = {sector, compare_c, compare_b, compare_a};

    // The pipeline is empty right after reset.
    reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid directly after reset");

endmodule

// ===== design/svd_sine_lookup.sv =====
// ----------------------------------------------------------------------------
// svd_sine_lookup
// Front end: sector decode, depth clamp and table addressing in the first
// stage; sine table reads and depth scaling in the second stage.
// ----------------------------------------------------------------------------
module svd_sine_lookup
    import svd_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  svd_cfg_t    cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_depth,
    input  logic [15:0] in_angle,
    output logic        out_valid,
    input  logic        out_ready,
    output svd_sine_t   out_data
);

    localparam int SHIFT  = 16 - SINE_TABLE_BITS;
    localparam int IW     = SINE_TABLE_BITS - 1;
    localparam int QDEPTH = (1 << (SINE_TABLE_BITS - 2)) + 1;
    localparam logic [15:0] QMASK = 16'(16'hffff << SHIFT);

    // Quarter-wave table, built at elaboration.
    logic [14:0] sine_rom [QDEPTH];

    for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
        assign sine_rom[g] = quarter_sine_q15(int'(unsigned'(g)) << SHIFT);
    end

    // Quantize an angle and fold it onto the quarter wave: {negate, index}.
    function automatic logic [IW:0] sine_addr(input logic [15:0] ang);
        logic [15:0] aq;
        logic [14:0] r;
        aq = ang & QMASK;
        r  = {1'b0, aq[13:0]};
        if (aq[14]) begin
            r = 15'd16384 - r;
        end
        return {aq[15], r[14:SHIFT]};
    endfunction

    function automatic svd_sector_t sector_of(input logic [15:0] ang);
        svd_sector_t s;
        if (ang != 16'd0 && ang < DEG60) begin
            s = SEC_1;
        end else if (ang >= DEG60 && ang < DEG120) begin
            s = SEC_2;
        end else if (ang >= DEG120 && ang < DEG180) begin
            s = SEC_3;
        end else if (ang >= DEG180 && ang < DEG240) begin
            s = SEC_4;
        end else if (ang >= DEG240 && ang < DEG300) begin
            s = SEC_5;
        end else begin
            s = SEC_6;
        end
        return s;
    endfunction

    function automatic logic signed [15:0] apply_sign(input logic neg, input logic [14:0] mag);
        logic signed [15:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // Stage A registers.
    logic          a_valid_reg;
    logic          a_valid_next;
    svd_sector_t   a_sec_reg;
    logic [15:0]   a_depth_reg;
    logic [IW:0]   a_addr_x_reg;
    logic [IW:0]   a_addr_y_reg;
    logic [IW:0]   a_addr_z_reg;
    logic          a_ready;

    // Stage B registers.
    logic          b_valid_reg;
    logic          b_valid_next;
    svd_sector_t   b_sec_reg;
    logic [15:0]   b_scale_reg;
    logic [14:0]   b_mag_x_reg;
    logic [14:0]   b_mag_y_reg;
    logic [14:0]   b_mag_z_reg;
    logic          b_neg_x_reg;
    logic          b_neg_y_reg;
    logic          b_neg_z_reg;
    logic          b_ready;

    logic [31:0]   scale_prod;

    // Each stage takes a new transaction when empty or when its contents move on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Stage A: sector, clamped depth and the three table addresses.
    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_sec_reg    <= sector_of(in_angle);
            a_depth_reg  <= (in_depth > cfg.depth_limit) ? cfg.depth_limit : in_depth;
            a_addr_x_reg <= sine_addr(in_angle);
            a_addr_y_reg <= sine_addr(in_angle + DEG60);
            a_addr_z_reg <= sine_addr(in_angle - DEG60);
        end
    end

    assign scale_prod = 32'(a_depth_reg) * 32'(cfg.pwm_period);

    // Stage B: registered table reads and the period-scaled depth.
    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_sec_reg   <= a_sec_reg;
            b_scale_reg <= scale_prod[31:16];
            b_mag_x_reg <= sine_rom[a_addr_x_reg[IW-1:0]];
            b_mag_y_reg <= sine_rom[a_addr_y_reg[IW-1:0]];
            b_mag_z_reg <= sine_rom[a_addr_z_reg[IW-1:0]];
            b_neg_x_reg <= a_addr_x_reg[IW];
            b_neg_y_reg <= a_addr_y_reg[IW];
            b_neg_z_reg <= a_addr_z_reg[IW];
        end
    end

    assign out_valid      = b_valid_reg;
    assign out_data.ux    = apply_sign(b_neg_x_reg, b_mag_x_reg);
    assign out_data.uy    = apply_sign(b_neg_y_reg, b_mag_y_reg);
    assign out_data.uz    = apply_sign(b_neg_z_reg, b_mag_z_reg);
    assign out_data.scale = b_scale_reg;
    assign out_data.sec   = b_sec_reg;

    // In the first sector the sine at theta lies in the first quadrant.
    a_sec1_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_sec_reg == SEC_1) |-> !a_addr_x_reg[IW])
        else $error("sector 1 item addresses a negative sine at theta");

endmodule

// ===== design/svd_vector_time.sv =====
// ----------------------------------------------------------------------------
// svd_vector_time
// Active-vector times from the sector's sine terms, then the zero-vector
// split into the three unpermuted compare times.
// ----------------------------------------------------------------------------
module svd_vector_time
    import svd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  svd_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  svd_sine_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output svd_time_t out_data
);

    // Stage C registers.
    logic        c_valid_reg;
    logic        c_valid_next;
    logic [14:0] c_ea_reg;
    logic [14:0] c_eb_reg;
    svd_sector_t c_sec_reg;
    logic        c_ready;

    // Stage D registers.
    logic        d_valid_reg;
    logic        d_valid_next;
    svd_time_t   d_time_reg;
    logic        d_ready;

    logic signed [15:0] va;
    logic signed [15:0] vb;
    logic [14:0]        va_pos;
    logic [14:0]        vb_pos;
    logic [30:0]        prod_a;
    logic [30:0]        prod_b;

    logic [14:0]        half;
    logic signed [17:0] zero;
    logic [13:0]        tc;
    logic [16:0]        tb;
    logic [16:0]        ta;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb begin
        c_valid_next = c_ready ? in_valid : c_valid_reg;
        d_valid_next = d_ready ? c_valid_reg : d_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // Pick the two vector terms of the sector; negative terms count as zero.
    always_comb begin
        case (in_data.sec)
            SEC_1: begin
                va = -in_data.uz;
                vb = in_data.ux;
            end
            SEC_2: begin
                va = in_data.uz;
                vb = in_data.uy;
            end
            SEC_3: begin
                va = in_data.ux;
                vb = -in_data.uy;
            end
            SEC_4: begin
                va = -in_data.ux;
                vb = in_data.uz;
            end
            SEC_5: begin
                va = -in_data.uy;
                vb = -in_data.uz;
            end
            default: begin
                va = in_data.uy;
                vb = -in_data.ux;
            end
        endcase
        va_pos = va[15] ? 15'd0 : va[14:0];
        vb_pos = vb[15] ? 15'd0 : vb[14:0];
        prod_a = 31'(in_data.scale) * 31'(va_pos);
        prod_b = 31'(in_data.scale) * 31'(vb_pos);
    end

    // Stage C: the two active-vector times.
    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_ea_reg  <= prod_a[30:16];
            c_eb_reg  <= prod_b[30:16];
            c_sec_reg <= in_data.sec;
        end
    end

    // Zero-vector time is split evenly; it saturates at zero when overdriven.
    always_comb begin
        half = cfg.pwm_period[15:1];
        zero = $signed({3'b000, half}) - $signed({3'b000, c_ea_reg})
             - $signed({3'b000, c_eb_reg});
        tc   = zero[17] ? 14'd0 : zero[14:1];
        tb   = 17'(tc) + 17'(c_eb_reg);
        ta   = tb + 17'(c_ea_reg);
    end

    // Stage D: the three compare times before the sector permutation.
    always_ff @(posedge aclk) begin
        if (d_ready && c_valid_reg) begin
            d_time_reg.ta  <= ta;
            d_time_reg.tb  <= tb;
            d_time_reg.tc  <= 17'(tc);
            d_time_reg.sec <= c_sec_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_time_reg;

    // The compare times are ordered by construction.
    d_time_order: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg |-> (d_time_reg.ta >= d_time_reg.tb && d_time_reg.tb >= d_time_reg.tc))
        else $error("compare times out of order");

endmodule

// ===== design/svd_compare_limit.sv =====
// ----------------------------------------------------------------------------
// svd_compare_limit
// Sector permutation of the compare times and the dead-time limits, into
// the output register.
// ----------------------------------------------------------------------------
module svd_compare_limit
    import svd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  svd_cfg_t    cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  svd_time_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] out_compare_a,
    output logic [14:0] out_compare_b,
    output logic [14:0] out_compare_c,
    output logic [2:0]  out_sector
);

    logic        e_valid_reg;
    logic        e_valid_next;
    logic [14:0] e_ca_reg;
    logic [14:0] e_cb_reg;
    logic [14:0] e_cc_reg;
    svd_sector_t e_sec_reg;

    logic [16:0] ca;
    logic [16:0] cb;
    logic [16:0] cc;
    logic [14:0] half;
    logic [14:0] hi;

    // Lower limit first, then the upper one, which wins when they cross.
    function automatic logic [14:0] limit(input logic [16:0] v, input logic [13:0] lo,
                                          input logic [14:0] hi_lim);
        logic [16:0] x;
        x = v;
        if (x < 17'(lo)) begin
            x = 17'(lo);
        end
        if (x > 17'(hi_lim)) begin
            x = 17'(hi_lim);
        end
        return x[14:0];
    endfunction

    assign in_ready = !e_valid_reg || out_ready;

    always_comb begin
        e_valid_next = in_ready ? in_valid : e_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= e_valid_next;
        end
    end

    // Route the three times to the phases by sector.
    always_comb begin
        case (in_data.sec)
            SEC_1: begin
                ca = in_data.ta;
                cb = in_data.tb;
                cc = in_data.tc;
            end
            SEC_2: begin
                ca = in_data.tb;
                cb = in_data.ta;
                cc = in_data.tc;
            end
            SEC_3: begin
                ca = in_data.tc;
                cb = in_data.ta;
                cc = in_data.tb;
            end
            SEC_4: begin
                ca = in_data.tc;
                cb = in_data.tb;
                cc = in_data.ta;
            end
            SEC_5: begin
                ca = in_data.tb;
                cb = in_data.tc;
                cc = in_data.ta;
            end
            default: begin
                ca = in_data.ta;
                cb = in_data.tc;
                cc = in_data.tb;
            end
        endcase
        half = cfg.pwm_period[15:1];
        hi   = (half >= 15'(cfg.margin)) ? half - 15'(cfg.margin) : 15'd0;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            e_ca_reg  <= limit(ca, cfg.margin, hi);
            e_cb_reg  <= limit(cb, cfg.margin, hi);
            e_cc_reg  <= limit(cc, cfg.margin, hi);
            e_sec_reg <= in_data.sec;
        end
    end

    assign out_valid     = e_valid_reg;
    assign out_compare_a = e_ca_reg;
    assign out_compare_b = e_cb_reg;
    assign out_compare_c = e_cc_reg;
    assign out_sector    = e_sec_reg;

    // Limiting keeps the sector-one ordering of the phases.
    e_sec1_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && e_sec_reg == SEC_1) |-> (e_ca_reg >= e_cb_reg && e_cb_reg >= e_cc_reg))
        else $error("sector 1 compare values out of order");

endmodule

// ===== tb/tb_svpwm_duty_generator.sv =====
// ----------------------------------------------------------------------------
// tb_svpwm_duty_generator
// Self-checking testbench for the space-vector PWM duty generator.
// ----------------------------------------------------------------------------
// A short directed table covers angle zero, every sector boundary, zero and
// full depth, and the corner cases of the limit stage. These are saturated
// zero-vector time, a dead time above half the period, and periods of one
// and zero. Random phases then follow, each with its own register setting
// and one of four patterns of sender gaps and receiver stalls. Every result
// transaction is compared with an in-bench model of the sine lookup and the
// compare arithmetic.
// ----------------------------------------------------------------------------
module tb_svpwm_duty_generator;
    import svd_pkg::*;

    localparam int SINE_BITS       = 10;
    localparam int ITEMS_PER_PHASE = 132;
    localparam int NUM_PHASES      = 8;
    localparam int NUM_DIR         = 27;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // One result transaction, unpacked into its fields.
    typedef struct packed {
        logic [14:0] cmp_a;
        logic [14:0] cmp_b;
        logic [14:0] cmp_c;
        svd_sector_t sec;
    } duty_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    // Directed stimulus row: a register write or an input transaction, the
    // latter optionally with a hand-computed result.
    typedef struct packed {
        row_kind_t   kind;
        svd_reg_t    idx;
        logic [15:0] val;
        logic [15:0] depth;
        logic [15:0] angle;
        duty_t       want;
    } dir_row_t;

    localparam duty_t NO_DUTY = '{15'd0, 15'd0, 15'd0, SEC_1};

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = 2'd0;
    logic [15:0] cfg_data      = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;   // depth[15:0], angle[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // compare_a[14:0], compare_b[29:15],
                                          // compare_c[44:30], sector[47:45]

    // Register values as the block should currently hold them.
    logic [15:0] cur_depth_limit = DEPTH_LIMIT_RESET;
    logic [15:0] cur_pwm_period  = PWM_PERIOD_RESET;
    logic [13:0] cur_margin      = MARGIN_RESET;

    duty_t duty_expected[$];
    int    error_count    = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;

    logic [15:0] sector_edge [6] = '{16'd0, DEG60, DEG120, DEG180, DEG240, DEG300};

    // Directed table. Known rows at reset settings with zero depth sit at
    // half of the half period; rows after the large dead time or the tiny
    // periods collapse to zero.
    dir_row_t dir_rows [NUM_DIR] = '{
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'd0, 16'd0,
          '{15'd1200, 15'd1200, 15'd1200, SEC_6}},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'd0, 16'd1,
          '{15'd1200, 15'd1200, 15'd1200, SEC_1}},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'd0, 16'hffff,
          '{15'd1200, 15'd1200, 15'd1200, SEC_6}},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'hffff, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd10922, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd10923, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd21844, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd21845, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd32767, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd32768, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd43690, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd43691, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd54612, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd54613, NO_DUTY},
        // Thirty degrees into a sector at high depth; once the depth limit
        // is lifted the zero-vector time saturates.
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd5461, NO_DUTY},
        '{ROW_CFG, REG_DEPTH_LIMIT, 16'hffff, 16'd0, 16'd0, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'd38229, NO_DUTY},
        '{ROW_ITEM, REG_DEPTH_LIMIT, 16'd0, 16'd1, 16'd16384, NO_DUTY},
        // Dead time above half the period forces every compare to zero.
        '{ROW_CFG, REG_PWM_PERIOD, 16'd100, 16'd0, 16'd0, NO_DUTY},
        '{ROW_CFG, REG_MARGIN, 16'd60, 16'd0, 16'd0, NO_DUTY},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'h8000, 16'h1234,
          '{15'd0, 15'd0, 15'd0, SEC_1}},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'hc000,
          '{15'd0, 15'd0, 15'd0, SEC_5}},
        // Periods of one and zero leave no compare range.
        '{ROW_CFG, REG_MARGIN, 16'd0, 16'd0, 16'd0, NO_DUTY},
        '{ROW_CFG, REG_PWM_PERIOD, 16'd1, 16'd0, 16'd0, NO_DUTY},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'h4000,
          '{15'd0, 15'd0, 15'd0, SEC_2}},
        '{ROW_CFG, REG_PWM_PERIOD, 16'd0, 16'd0, 16'd0, NO_DUTY},
        '{ROW_KNOWN, REG_DEPTH_LIMIT, 16'd0, 16'hffff, 16'h8000,
          '{15'd0, 15'd0, 15'd0, SEC_4}}
    };

    svpwm_duty_generator #(
        .SINE_TABLE_BITS(SINE_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // (a * b) >> 62 on unsigned Q62 operands.
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // Taylor series of sin(pi/2 * r / 16384) in Q62, r in 0..16384.
    function automatic logic [63:0] quarter_wave_q62(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        x    = (HALF_PI_Q62 >> 14) * 64'(r);
        x2   = q62_product(x, x);
        term = x;
        sum  = x;
        for (k = 1; k <= 12; k++) begin
            term = q62_product(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Signed Q15 sine of a 16-bit angle cut down to the table resolution.
    function automatic int sine_q15(input logic [15:0] ang);
        logic [15:0] a;
        int unsigned r;
        logic [63:0] s;
        logic [63:0] v;
        a = (ang >> (16 - SINE_BITS)) << (16 - SINE_BITS);
        r = a[13:0];
        if (a[14]) begin
            r = 16384 - r;
        end
        s = quarter_wave_q62(r);
        v = ((s >> 30) * 64'd32767 + 64'h8000_0000) >> 32;
        if (v > 64'(AMP_Q15)) begin
            v = 64'(AMP_Q15);
        end
        return a[15] ? -int'(v) : int'(v);
    endfunction

    function automatic int unsigned bound(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    // Compare values and sector for one input under the current registers.
    function automatic duty_t predict_duty(input logic [15:0] depth, input logic [15:0] angle);
        svd_sector_t sec;
        int          ux, uy, uz, va, vb, zero;
        int unsigned d, scale, ea, eb, half, tc, tb, ta, lo, hi, ca, cb, cc;
        duty_t       r;
        if (angle == 16'd0) begin
            sec = SEC_6;
        end else if (angle < DEG60) begin
            sec = SEC_1;
        end else if (angle < DEG120) begin
            sec = SEC_2;
        end else if (angle < DEG180) begin
            sec = SEC_3;
        end else if (angle < DEG240) begin
            sec = SEC_4;
        end else if (angle < DEG300) begin
            sec = SEC_5;
        end else begin
            sec = SEC_6;
        end

        ux = sine_q15(angle);
        uy = sine_q15(16'(angle + DEG60));
        uz = sine_q15(16'(angle - DEG60));

        // Active-vector terms of the sector, negative terms clamped to zero.
        case (sec)
            SEC_1: begin va = -uz; vb = ux;  end
            SEC_2: begin va = uz;  vb = uy;  end
            SEC_3: begin va = ux;  vb = -uy; end
            SEC_4: begin va = -ux; vb = uz;  end
            SEC_5: begin va = -uy; vb = -uz; end
            default: begin va = uy; vb = -ux; end
        endcase
        if (va < 0) begin
            va = 0;
        end
        if (vb < 0) begin
            vb = 0;
        end

        d     = (depth > cur_depth_limit) ? cur_depth_limit : depth;
        scale = (d * cur_pwm_period) >> 16;
        ea    = (scale * $unsigned(va)) >> 16;
        eb    = (scale * $unsigned(vb)) >> 16;
        half  = cur_pwm_period >> 1;
        zero  = int'(half) - int'(ea) - int'(eb);
        tc    = (zero < 0) ? 0 : ($unsigned(zero) >> 1);
        tb    = tc + eb;
        ta    = tb + ea;

        case (sec)
            SEC_1: begin ca = ta; cb = tb; cc = tc; end
            SEC_2: begin ca = tb; cb = ta; cc = tc; end
            SEC_3: begin ca = tc; cb = ta; cc = tb; end
            SEC_4: begin ca = tc; cb = tb; cc = ta; end
            SEC_5: begin ca = tb; cb = tc; cc = ta; end
            default: begin ca = ta; cb = tc; cc = tb; end
        endcase

        // The upper limit wins when the dead time exceeds half the period.
        lo      = cur_margin;
        hi      = (half >= lo) ? half - lo : 0;
        r.cmp_a = 15'(bound(ca, lo, hi));
        r.cmp_b = 15'(bound(cb, lo, hi));
        r.cmp_c = 15'(bound(cc, lo, hi));
        r.sec   = sec;
        return r;
    endfunction

    // One register write; the expected register copy follows the write.
    task automatic write_reg(input svd_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DEPTH_LIMIT: cur_depth_limit = val;
            REG_PWM_PERIOD:  cur_pwm_period  = val;
            REG_MARGIN:      cur_margin      = val[13:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // One input transaction with random gaps ahead of it. tvalid stays high
    // after acceptance so that back-to-back transactions need no extra edge.
    task automatic send_item(input logic [15:0] depth, input logic [15:0] angle,
                             input bit known, input duty_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {angle, depth};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        duty_expected.push_back(known ? want : predict_duty(depth, angle));
    endtask

    // Hold off the sender until every outstanding result has returned.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (duty_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result checking and random receiver stalls.
    always @(posedge aclk) begin : result_check
        duty_t got;
        duty_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.cmp_a = m_axis_tdata[14:0];
            got.cmp_b = m_axis_tdata[29:15];
            got.cmp_c = m_axis_tdata[44:30];
            got.sec   = svd_sector_t'(m_axis_tdata[47:45]);
            if (duty_expected.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected result transaction: a=%0d b=%0d c=%0d sector=%0d",
                             got.cmp_a, got.cmp_b, got.cmp_c, got.sec);
                end
            end else begin
                want = duty_expected.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Mismatch: expected a=%0d b=%0d c=%0d sector=%0d, %s",
                                 want.cmp_a, want.cmp_b, want.cmp_c, want.sec,
                                 $sformatf("got a=%0d b=%0d c=%0d sector=%0d",
                                           got.cmp_a, got.cmp_b, got.cmp_c, got.sec));
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus sequence.
    initial begin : stimulus
        int          i;
        int          p;
        int          n;
        int unsigned sel;
        int unsigned dead_max;
        dir_row_t    row;
        logic [15:0] depth;
        logic [15:0] angle;
        logic [15:0] lim;
        logic [15:0] per;
        logic [15:0] dt;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        for (i = 0; i < NUM_DIR; i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.idx, row.val);
            end else begin
                send_item(row.depth, row.angle, row.kind == ROW_KNOWN, row.want);
            end
        end

        // Random phases, each with its own registers and one of four flow-control mixes.
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p % 4)
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            case (p)
                0: begin lim = DEPTH_LIMIT_RESET; per = PWM_PERIOD_RESET;
                         dt = 16'(MARGIN_RESET); end
                1: begin lim = 16'hffff; per = 16'hffff; dt = 16'd0; end
                // Upper data bits beyond the dead-time width are dropped.
                2: begin lim = 16'd0; per = 16'd2; dt = 16'hffff; end
                3: begin lim = 16'd32768; per = 16'd20000; dt = 16'd500; end
                default: begin
                    lim      = 16'($urandom);
                    per      = 16'($urandom_range(2, 65535));
                    dead_max = (per >> 1) + 16;
                    if (dead_max > 16383) begin
                        dead_max = 16383;
                    end
                    dt = {2'($urandom), 14'($urandom_range(0, dead_max))};
                end
            endcase
            write_reg(REG_DEPTH_LIMIT, lim);
            write_reg(REG_PWM_PERIOD, per);
            write_reg(REG_MARGIN, dt);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    drain_results();
                end
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    depth = 16'd0;
                end else if (sel < 25) begin
                    depth = 16'hffff;
                end else if (sel < 35) begin
                    depth = cur_depth_limit + 16'($urandom_range(0, 4)) - 16'd2;
                end else begin
                    depth = 16'($urandom);
                end
                // Bias some angles onto the sector boundaries.
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    angle = sector_edge[$urandom_range(0, 5)]
                            + 16'($urandom_range(0, 4)) - 16'd2;
                end else begin
                    angle = 16'($urandom);
                end
                send_item(depth, angle, 1'b0, NO_DUTY);
            end
        end

        drain_results();
        if (error_count == 0 && duty_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
